@@ hdl/atlas_shelf_rect_allocator_assert.svh @@
// Assertion macros for the shelf rectangle allocator.
`ifndef ATLAS_SHELF_RECT_ALLOCATOR_ASSERT_SVH
`define ATLAS_SHELF_RECT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH

`define ASRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASRA_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASRA_ASSERT(lbl, clk, rst_n, prop, msg)

`define ASRA_ASSERT_ANY(lbl, clk, prop, msg)

`endif

`endif

@@ hdl/asra_pkg.sv @@
// Shared types and constants of the shelf rectangle allocator.
package asra_pkg;

    localparam logic [2:0] ST_EXISTING   = 3'd0;
    localparam logic [2:0] ST_NEW_ROW    = 3'd1;
    localparam logic [2:0] ST_MAX_SIZE   = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_CLEARED    = 3'd4;

    localparam logic [11:0] FAIL_SIZE       = 12'd2;
    localparam logic [16:0] MAX_SIZE_RESET  = 17'd8192;
    localparam logic [23:0] DIV10_RECIP     = 24'd3277;
    localparam int          DIV10_SHIFT     = 15;

    typedef struct packed {
        logic [16:0] top;
        logic [12:0] height;
        logic [15:0] used;
    } t_row;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] width;
        logic [11:0] height;
        logic [2:0]  status;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_ctrl_stat;

endpackage

@@ hdl/asra_req_if.sv @@
// Request channel of the shelf rectangle allocator.
interface asra_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [11:0] rect_width;
    logic [11:0] rect_height;

    modport source (output valid, mode, rect_width, rect_height, input ready);
    modport sink (input valid, mode, rect_width, rect_height, output ready);
endinterface

@@ hdl/asra_res_if.sv @@
// Result channel of the shelf rectangle allocator.
interface asra_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] out_width;
    logic [11:0] out_height;
    logic [16:0] atlas_height;
    logic [2:0]  status;

    modport source (output valid, pos_x, pos_y, out_width, out_height, atlas_height, status,
                    input ready);
    modport sink (input valid, pos_x, pos_y, out_width, out_height, atlas_height, status,
                  output ready);
endinterface

@@ hdl/asra_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module asra_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/asra_ctrl.sv @@
// Row scan and row creation sequencer of the shelf rectangle allocator.
module asra_ctrl #(
    parameter int MAX_ROWS       = 64,
    parameter int ATLAS_WIDTH    = 128,
    parameter int INITIAL_HEIGHT = 128,
    parameter int FIRST_ROW_TOP  = 3,
    parameter int ADDR_W         = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [16:0]          i_max_size,
    asra_req_if.sink             i_req,
    output asra_pkg::t_result    o_result,
    output logic [16:0]          o_atlas_height,
    output asra_pkg::t_ctrl_stat o_stat,
    input  logic                 i_res_take,
    output logic                 o_mem_we,
    output logic [ADDR_W-1:0]    o_mem_waddr,
    output asra_pkg::t_row       o_mem_wdata,
    output logic                 o_mem_re,
    output logic [ADDR_W-1:0]    o_mem_raddr,
    input  asra_pkg::t_row       i_mem_rdata
);

    localparam int          CNT_W      = $clog2(MAX_ROWS + 1);
    localparam logic [16:0] ATLAS_W17  = 17'(ATLAS_WIDTH);
    localparam logic [17:0] ATLAS_W2   = 18'(2 * ATLAS_WIDTH);
    localparam logic [16:0] INIT_H     = 17'(INITIAL_HEIGHT);
    localparam logic [16:0] FIRST_TOP  = 17'(FIRST_ROW_TOP);
    localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(MAX_ROWS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_GROW = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pidx, n_pidx;
    logic [16:0]       r_nft, n_nft;
    logic [16:0]       r_atlas, n_atlas;
    logic [11:0]       r_w, n_w;
    logic [11:0]       r_h, n_h;
    logic [15:0]       r_h10, n_h10;
    logic [12:0]       r_rh, n_rh;
    asra_pkg::t_result r_res, n_res;

    logic [23:0] w_prod;
    logic [15:0] w_7rh;
    logic        w_fit;
    logic        w_grow;
    logic        w_can_dbl;

    assign w_prod = 24'(i_req.rect_height) * asra_pkg::DIV10_RECIP;
    assign w_7rh  = {i_mem_rdata.height, 3'b000} - 16'(i_mem_rdata.height);
    assign w_fit  = (r_h10 >= w_7rh) && ({1'b0, r_h} <= i_mem_rdata.height) &&
                    ((17'(i_mem_rdata.used) + 17'(r_w)) <= ATLAS_W17);
    assign w_grow = ((18'(r_nft) + 18'(r_rh)) >= 18'(r_atlas)) || (17'(r_w) >= ATLAS_W17);
    assign w_can_dbl = (ATLAS_W2 <= 18'(i_max_size)) &&
                       ({r_atlas, 1'b0} <= 18'(i_max_size));

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_result       = r_res;
    assign o_atlas_height = r_atlas;
    assign o_stat.idle    = (r_state == S_IDLE);
    assign o_stat.done    = (r_state == S_DONE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd        = r_rd;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_nft       = r_nft;
        n_atlas     = r_atlas;
        n_w         = r_w;
        n_h         = r_h;
        n_h10       = r_h10;
        n_rh        = r_rh;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_w    = i_req.rect_width;
                    n_h    = i_req.rect_height;
                    n_h10  = {1'b0, i_req.rect_height, 3'b000} + {3'b000, i_req.rect_height, 1'b0};
                    n_rh   = 13'(i_req.rect_height) +
                             13'(w_prod[23:asra_pkg::DIV10_SHIFT]);
                    n_rd   = '0;
                    n_pend = 1'b0;
                    if (i_req.mode) begin
                        n_cnt   = '0;
                        n_nft   = FIRST_TOP;
                        n_atlas = INIT_H;
                        n_res   = '{pos_x: 16'd0, pos_y: 16'd0, width: 12'd0, height: 12'd0,
                                    status: asra_pkg::ST_CLEARED};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && w_fit) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pidx;
                    o_mem_wdata = '{top: i_mem_rdata.top, height: i_mem_rdata.height,
                                    used: 16'(17'(i_mem_rdata.used) + 17'(r_w))};
                    n_res       = '{pos_x: i_mem_rdata.used, pos_y: i_mem_rdata.top[15:0],
                                    width: r_w, height: r_h, status: asra_pkg::ST_EXISTING};
                    n_state     = S_DONE;
                end else if (r_rd < r_cnt) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_rd[ADDR_W-1:0];
                    n_rd        = r_rd + 1'b1;
                    n_pend      = 1'b1;
                    n_pidx      = r_rd[ADDR_W-1:0];
                end else if (r_cnt >= ROWS_C) begin
                    n_res   = '{pos_x: 16'd0, pos_y: 16'd0, width: asra_pkg::FAIL_SIZE,
                                height: asra_pkg::FAIL_SIZE, status: asra_pkg::ST_TABLE_FULL};
                    n_state = S_DONE;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                if (w_grow) begin
                    if (w_can_dbl) begin
                        n_atlas = {r_atlas[15:0], 1'b0};
                    end else begin
                        n_res   = '{pos_x: 16'd0, pos_y: 16'd0, width: asra_pkg::FAIL_SIZE,
                                    height: asra_pkg::FAIL_SIZE, status: asra_pkg::ST_MAX_SIZE};
                        n_state = S_DONE;
                    end
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_cnt[ADDR_W-1:0];
                    o_mem_wdata = '{top: r_nft, height: r_rh, used: 16'(r_w)};
                    n_cnt       = r_cnt + 1'b1;
                    n_nft       = 17'(18'(r_nft) + 18'(r_rh));
                    n_res       = '{pos_x: 16'd0, pos_y: r_nft[15:0], width: r_w, height: r_h,
                                    status: asra_pkg::ST_NEW_ROW};
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_pend  <= 1'b0;
            r_nft   <= FIRST_TOP;
            r_atlas <= INIT_H;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
            r_pend  <= n_pend;
            r_nft   <= n_nft;
            r_atlas <= n_atlas;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_w    <= n_w;
        r_h    <= n_h;
        r_h10  <= n_h10;
        r_rh   <= n_rh;
        r_res  <= n_res;
    end

endmodule

@@ hdl/atlas_shelf_rect_allocator.sv @@
// Top level of the shelf rectangle allocator: row memory, sequencer, output register.
//
// Channel   Dir  Payload                                          Transfer
// i_req     in   mode, rect_width, rect_height                    valid & ready
// o_res     out  pos_x, pos_y, out_width, out_height,             valid & ready
//                atlas_height, status
// i_cfg     in   max_texture_size (17 bits)                       i_cfg_wr_en
//
// A clear needs no row memory access; an allocation scans the rows in order and takes
// the first that fits, else doubles the atlas height as needed and opens a new row.
// The scan reads one row per cycle; a full row table fails once all rows are scanned.
// Reset is synchronous; the row memory needs no clearing since only rows below the
// row count are read. A new request is taken once the previous result has moved into
// the output register, which holds it while o_res.ready is low.
`include "atlas_shelf_rect_allocator_assert.svh"

module atlas_shelf_rect_allocator #(
    parameter int MAX_ROWS       = 64,
    parameter int ATLAS_WIDTH    = 128,
    parameter int INITIAL_HEIGHT = 128,
    parameter int FIRST_ROW_TOP  = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [16:0] i_cfg_wr_data,
    asra_req_if.sink    i_req,
    asra_res_if.source  o_res
);

    localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_W  = $bits(asra_pkg::t_row);

    logic [16:0]          r_max_size;
    logic                 r_out_vld;
    asra_pkg::t_result    r_out;
    logic [16:0]          r_out_atlas;

    asra_pkg::t_result    w_result;
    logic [16:0]          w_atlas;
    asra_pkg::t_ctrl_stat w_stat;
    logic                 w_res_take;
    logic                 w_mem_we;
    logic [ADDR_W-1:0]    w_mem_waddr;
    asra_pkg::t_row       w_mem_wdata;
    logic                 w_mem_re;
    logic [ADDR_W-1:0]    w_mem_raddr;
    logic [ROW_W-1:0]     w_mem_rdata;

    assign w_res_take = w_stat.done && (!r_out_vld || o_res.ready);

    asra_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    asra_ctrl #(
        .MAX_ROWS       (MAX_ROWS),
        .ATLAS_WIDTH    (ATLAS_WIDTH),
        .INITIAL_HEIGHT (INITIAL_HEIGHT),
        .FIRST_ROW_TOP  (FIRST_ROW_TOP),
        .ADDR_W         (ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_size     (r_max_size),
        .i_req          (i_req),
        .o_result       (w_result),
        .o_atlas_height (w_atlas),
        .o_stat         (w_stat),
        .i_res_take     (w_res_take),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata),
        .o_mem_re       (w_mem_re),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (asra_pkg::t_row'(w_mem_rdata))
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= asra_pkg::MAX_SIZE_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_size <= i_cfg_wr_data;
            end
            if (w_res_take) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out       <= w_result;
            r_out_atlas <= w_atlas;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.pos_x        = r_out.pos_x;
    assign o_res.pos_y        = r_out.pos_y;
    assign o_res.out_width    = r_out.width;
    assign o_res.out_height   = r_out.height;
    assign o_res.atlas_height = r_out_atlas;
    assign o_res.status       = r_out.status;

    `ASRA_ASSERT(a_one_item_at_a_time, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready, "request taken while busy")
    `ASRA_ASSERT(a_status_code, i_clk, i_rst_n, o_res.valid |-> (o_res.status <= asra_pkg::ST_CLEARED), "invalid status code")
    `ASRA_ASSERT(a_result_held, i_clk, i_rst_n, (w_stat.done && !w_res_take) |=> w_stat.done, "result dropped before transfer")
    `ASRA_ASSERT_ANY(a_reset_idle, i_clk, !i_rst_n |=> (w_stat.idle && !r_out_vld), "not idle after reset")

endmodule

@@ tb/tb.sv @@
// Testbench for the shelf rectangle allocator: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int ATLAS_W        = 128;
    localparam int ROW_LIMIT      = 64;
    localparam int START_HEIGHT   = 128;
    localparam int START_TOP      = 3;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 104;
    localparam int BURST_ITEMS    = 68;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] width;
        logic [11:0] height;
        logic [16:0] atlas_height;
        logic [2:0]  status;
    } t_placement;

    class t_atlas_scoreboard;
        int         row_top[ROW_LIMIT];
        int         row_h[ROW_LIMIT];
        int         row_used[ROW_LIMIT];
        int         row_count;
        int         next_top;
        int         atlas_h;
        int         max_side;
        int         errors;
        int         results_seen;
        int         outcome_seen[5];
        t_placement placements_due[$];

        function new();
            max_side = int'(asra_pkg::MAX_SIZE_RESET);
            errors = 0;
            results_seen = 0;
            foreach (outcome_seen[i]) outcome_seen[i] = 0;
            clear_page();
        endfunction

        function void clear_page();
            row_count = 0;
            next_top = START_TOP;
            atlas_h = START_HEIGHT;
        endfunction

        function void set_max_side(int v);
            max_side = v & 'h1FFFF;
        endfunction

        function int pending();
            return placements_due.size();
        endfunction

        function void push_placement(int x, int y, int w, int h, logic [2:0] st);
            t_placement p;
            p.pos_x = x[15:0];
            p.pos_y = y[15:0];
            p.width = w[11:0];
            p.height = h[11:0];
            p.atlas_height = atlas_h[16:0];
            p.status = st;
            placements_due.insert(placements_due.size(), p);
        endfunction

        function void note_request(bit clear_req, bit [11:0] w, bit [11:0] h);
            int wi;
            int hi;
            int hit;
            int rh;
            wi = int'(w);
            hi = int'(h);
            hit = -1;
            if (clear_req) begin
                clear_page();
                push_placement(0, 0, 0, 0, asra_pkg::ST_CLEARED);
                return;
            end
            for (int i = 0; i < row_count; i++) begin
                if (hit < 0 && 10 * hi >= 7 * row_h[i] && hi <= row_h[i] &&
                    row_used[i] <= ATLAS_W && wi <= ATLAS_W - row_used[i]) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                push_placement(row_used[hit], row_top[hit], wi, hi, asra_pkg::ST_EXISTING);
                row_used[hit] = (row_used[hit] + wi) & 'hFFFF;
                return;
            end
            if (row_count >= ROW_LIMIT) begin
                push_placement(0, 0, int'(asra_pkg::FAIL_SIZE), int'(asra_pkg::FAIL_SIZE),
                               asra_pkg::ST_TABLE_FULL);
                return;
            end
            rh = hi + hi / 10;
            while (next_top + rh >= atlas_h || wi >= ATLAS_W) begin
                if (2 * ATLAS_W <= max_side && 2 * atlas_h <= max_side) begin
                    atlas_h = (2 * atlas_h) & 'h1FFFF;
                end else begin
                    push_placement(0, 0, int'(asra_pkg::FAIL_SIZE), int'(asra_pkg::FAIL_SIZE),
                                   asra_pkg::ST_MAX_SIZE);
                    return;
                end
            end
            row_top[row_count] = next_top & 'h1FFFF;
            row_h[row_count] = rh & 'h1FFF;
            row_used[row_count] = wi & 'hFFFF;
            push_placement(0, row_top[row_count], wi, hi, asra_pkg::ST_NEW_ROW);
            row_count++;
            next_top = (next_top + rh) & 'h1FFFF;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want) begin
                report($sformatf("result %0d field %s: got %0d, expected %0d",
                                 results_seen, name, got, want));
            end
        endtask

        task check_result(t_placement got);
            t_placement want;
            if (placements_due.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", results_seen));
                results_seen++;
                return;
            end
            want = placements_due.pop_front();
            compare_field("pos_x", int'(got.pos_x), int'(want.pos_x));
            compare_field("pos_y", int'(got.pos_y), int'(want.pos_y));
            compare_field("out_width", int'(got.width), int'(want.width));
            compare_field("out_height", int'(got.height), int'(want.height));
            compare_field("atlas_height", int'(got.atlas_height), int'(want.atlas_height));
            compare_field("status", int'(got.status), int'(want.status));
            if (want.status <= asra_pkg::ST_CLEARED) outcome_seen[want.status]++;
            results_seen++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [16:0] i_cfg_wr_data;
    bit          calm;
    int          cycles;
    int          requests_sent;
    int          settings_used;

    asra_req_if req_ch ();
    asra_res_if res_ch ();

    atlas_shelf_rect_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req        (req_ch),
        .o_res        (res_ch)
    );

    t_atlas_scoreboard sb = new();

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result({res_ch.pos_x, res_ch.pos_y, res_ch.out_width, res_ch.out_height,
                             res_ch.atlas_height, res_ch.status});
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (calm || r < 50) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    task automatic send_item(bit m, bit [11:0] w, bit [11:0] h);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode = m;
        req_ch.rect_width = w;
        req_ch.rect_height = h;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(m, w, h);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_max_side(int v);
        req_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v[16:0];
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.set_max_side(v);
        settings_used++;
    endtask

    task automatic make_item(int base, output bit m, output bit [11:0] w, output bit [11:0] h);
        int r;
        bit [31:0] raw;
        r = int'($urandom_range(0, 99));
        m = 1'b0;
        w = 12'($urandom_range(1, 40));
        h = 12'(base + int'($urandom_range(0, base / 3 + 1)));
        if (r < 4) begin
            m = 1'b1;
        end else if (r < 14) begin
            w = 12'($urandom_range(64, 127));
            h = 12'($urandom_range(0, base));
        end else if (r < 18) begin
            w = 12'($urandom_range(128, 4095));
        end else if (r < 23) begin
            h = 12'($urandom_range(0, 4095));
        end else if (r < 30) begin
            raw = $urandom;
            m = raw[24];
            w = raw[23:12];
            h = raw[11:0];
        end
    endtask

    task automatic fill_rows();
        send_item(1'b1, 12'd0, 12'd0);
        for (int k = 0; k < BURST_ITEMS; k++) begin
            send_item(1'b0, 12'($urandom_range(65, 127)), 12'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int limits[6];
        int base;
        int burst_at;
        bit m;
        bit [11:0] w;
        bit [11:0] h;
        limits = '{128, 65536, 256, 0, 8192, 0};
        cycles = 0;
        requests_sent = 0;
        settings_used = 1;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 17'd0;
        req_ch.valid = 1'b0;
        req_ch.mode = 1'b0;
        req_ch.rect_width = 12'd0;
        req_ch.rect_height = 12'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(1'b0, 12'd0, 12'd0);
        send_item(1'b0, 12'd0, 12'd0);
        send_item(1'b0, 12'd5, 12'd0);
        send_item(1'b0, 12'd127, 12'd20);
        send_item(1'b0, 12'd0, 12'd14);
        send_item(1'b0, 12'd0, 12'd16);
        send_item(1'b0, 12'd1, 12'd16);
        send_item(1'b0, 12'd1, 12'd16);
        send_item(1'b0, 12'd128, 12'd5);
        send_item(1'b0, 12'd4095, 12'd4095);
        send_item(1'b0, 12'd0, 12'd4095);
        send_item(1'b0, 12'd0, 12'd4095);
        send_item(1'b0, 12'd127, 12'd4095);
        send_item(1'b0, 12'd4095, 12'd0);
        send_item(1'b1, 12'd4095, 12'd4095);
        send_item(1'b0, 12'd0, 12'd200);
        send_item(1'b0, 12'hAAA, 12'h555);
        send_item(1'b0, 12'h555, 12'hAAA);
        send_item(1'b0, 12'd64, 12'd7);
        send_item(1'b0, 12'd64, 12'd7);
        send_item(1'b0, 12'd0, 12'd5);
        send_item(1'b1, 12'd0, 12'd0);

        for (int p = 0; p < 6; p++) begin
            write_max_side(limits[p] != 0 ? limits[p] : int'($urandom_range(129, 65535)));
            base = int'($urandom_range(2, 30));
            burst_at = (p % 2 == 0) ? int'($urandom_range(0, PHASE_ITEMS - 25)) : -1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                calm = ((k / 8) % 6) == 5;
                if (k == burst_at) fill_rows();
                make_item(base, m, w, h);
                send_item(m, w, h);
            end
            calm = 1'b0;
        end

        req_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("Sent %0d requests under %0d register settings, %0d results checked.",
                 requests_sent, settings_used, sb.results_seen);
        $display("Outcomes: %0d existing row, %0d new row, %0d size limit, %0d table full, %0d clear.",
                 sb.outcome_seen[asra_pkg::ST_EXISTING], sb.outcome_seen[asra_pkg::ST_NEW_ROW],
                 sb.outcome_seen[asra_pkg::ST_MAX_SIZE],
                 sb.outcome_seen[asra_pkg::ST_TABLE_FULL],
                 sb.outcome_seen[asra_pkg::ST_CLEARED]);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
